### hdl/oae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oae_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // request codes
    localparam logic [3:0] REQ_PUSH   = 4'd0;
    localparam logic [3:0] REQ_POP    = 4'd1;
    localparam logic [3:0] REQ_INSERT = 4'd2;
    localparam logic [3:0] REQ_ERASE  = 4'd3;
    localparam logic [3:0] REQ_READ   = 4'd4;
    localparam logic [3:0] REQ_WRITE  = 4'd5;
    localparam logic [3:0] REQ_FIND_F = 4'd6;
    localparam logic [3:0] REQ_FIND_L = 4'd7;
    localparam logic [3:0] REQ_RESIZE = 4'd8;
    localparam logic [3:0] REQ_CLEAR  = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [6:0]         index;
        logic [6:0]         count;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_data;
        logic               found;
        logic [5:0]         found_index;
        logic [6:0]         fill_level;
    } t_res;

    typedef struct packed {
        logic capture;
        logic setup;
        logic walk;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

### hdl/oae_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module oae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/oae_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module oae_ctrl
    import oae_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd,
    output logic          o_busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SETUP  = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_COMMIT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### hdl/oae_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module oae_dpath
    import oae_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_req     i_req,
    input  wire t_ctl_cmd i_cmd,
    input  wire logic     i_out_stall,
    output t_ctl_sts      o_sts,
    output logic          o_out_valid,
    output t_res          o_res
);

    // captured item
    logic [3:0]            r_req_type;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_WIDTH-1:0] r_val;

    logic [CNT_W-1:0]      r_count;
    logic [1:0]            r_status;
    logic [CNT_W-1:0]      r_ptr;
    logic [CNT_W-1:0]      r_left;
    logic                  r_pend;
    logic [ADDR_W-1:0]     r_paddr;
    logic                  r_found;
    logic [ADDR_W-1:0]     r_fidx;
    logic                  r_out_valid;
    t_res                  r_res;

    logic [1:0]            n_status;
    logic [CNT_W-1:0]      n_ptr;
    logic [CNT_W-1:0]      n_left;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W:0]        w_end;
    logic                  w_fill;
    logic                  w_down;
    logic                  w_find;
    logic                  w_issue;

    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rdata;

    assign w_end  = {1'b0, r_idx} + {1'b0, r_cnt};
    assign w_fill = (r_req_type == REQ_RESIZE);
    assign w_down = (r_req_type == REQ_INSERT) || (r_req_type == REQ_FIND_L);
    assign w_find = (r_req_type == REQ_FIND_F) || (r_req_type == REQ_FIND_L);
    assign w_issue = i_cmd.walk && !w_fill && (r_left != '0);

    // request check and walk bounds
    always_comb begin
        n_status = ST_OK;
        n_ptr    = '0;
        n_left   = '0;
        unique case (r_req_type)
            REQ_PUSH: begin
                if (r_count >= CNT_W'(DEPTH)) n_status = ST_FULL;
            end
            REQ_POP: begin
                if (r_count == '0) n_status = ST_EMPTY;
            end
            REQ_INSERT: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else if (r_idx > r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_ptr  = r_count - 1'b1;
                    n_left = r_count - r_idx;
                end
            end
            REQ_ERASE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_end > {1'b0, r_count}) begin
                    n_status = ST_RANGE;
                end else begin
                    n_ptr  = w_end[CNT_W-1:0];
                    n_left = r_count - w_end[CNT_W-1:0];
                end
            end
            REQ_READ: begin
                if (r_idx >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_ptr  = r_idx;
                    n_left = CNT_W'(1);
                end
            end
            REQ_WRITE: begin
                if (r_idx >= r_count) n_status = ST_RANGE;
            end
            REQ_FIND_F: begin
                n_ptr  = '0;
                n_left = r_count;
            end
            REQ_FIND_L: begin
                n_ptr  = r_count - 1'b1;
                n_left = r_count;
            end
            REQ_RESIZE: begin
                if (r_cnt > CNT_W'(DEPTH)) begin
                    n_status = ST_RANGE;
                end else begin
                    n_ptr = r_count;
                    if (r_cnt > r_count) n_left = r_cnt - r_count;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    // fill count after the item
    always_comb begin
        n_count = r_count;
        if (r_status == ST_OK) begin
            unique case (r_req_type)
                REQ_PUSH:   n_count = r_count + 1'b1;
                REQ_POP:    n_count = r_count - 1'b1;
                REQ_INSERT: n_count = r_count + 1'b1;
                REQ_ERASE:  n_count = r_count - r_cnt;
                REQ_RESIZE: n_count = r_cnt;
                REQ_CLEAR:  n_count = '0;
                default:    n_count = r_count;
            endcase
        end
    end

    // memory write port: shifts and fills during the walk, single writes at commit
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_val;
        if (i_cmd.walk) begin
            if (w_fill) begin
                w_we    = (r_left != '0);
                w_waddr = r_ptr[ADDR_W-1:0];
            end else if (r_pend && (r_req_type == REQ_INSERT)) begin
                w_we    = 1'b1;
                w_waddr = r_paddr + 1'b1;
                w_wdata = w_rdata;
            end else if (r_pend && (r_req_type == REQ_ERASE)) begin
                w_we    = 1'b1;
                w_waddr = r_paddr - r_cnt[ADDR_W-1:0];
                w_wdata = w_rdata;
            end
        end else if (i_cmd.commit && (r_status == ST_OK)) begin
            unique case (r_req_type)
                REQ_PUSH: begin
                    w_we    = 1'b1;
                    w_waddr = r_count[ADDR_W-1:0];
                end
                REQ_INSERT, REQ_WRITE: begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[ADDR_W-1:0];
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    oae_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req.req_type;
            r_idx      <= i_req.index;
            r_cnt      <= i_req.count;
            r_val      <= DATA_WIDTH'(i_req.value);
        end

        if (i_cmd.setup) begin
            r_status <= n_status;
            r_ptr    <= n_ptr;
            r_left   <= (n_status == ST_OK) ? n_left : '0;
            r_found  <= 1'b0;
            r_fidx   <= '0;
        end else if (i_cmd.walk) begin
            if (w_issue || (w_fill && (r_left != '0))) begin
                r_ptr  <= w_down ? r_ptr - 1'b1 : r_ptr + 1'b1;
                r_left <= r_left - 1'b1;
            end
            r_paddr <= r_ptr[ADDR_W-1:0];
            // first hit in walk order wins
            if (r_pend && w_find && !r_found && (w_rdata == r_val)) begin
                r_found <= 1'b1;
                r_fidx  <= r_paddr;
            end
        end

        if (i_cmd.commit) begin
            r_res.status      <= r_status;
            r_res.read_data   <= ((r_req_type == REQ_READ) && (r_status == ST_OK))
                                 ? w_rdata : '0;
            r_res.found       <= r_found;
            r_res.found_index <= r_fidx;
            r_res.fill_level  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_pend <= 1'b0;
            end else if (i_cmd.walk) begin
                r_pend <= w_issue;
            end
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.walk_done = ((r_left == '0) && !r_pend) || r_found;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_res           = r_res;

endmodule

`default_nettype wire

### hdl/ordered_array_engine_core.sv
// ordered array engine: a packed array of up to 64 signed words with a fill count.
// input channel: i_valid / o_stall carry one request item (i_req); it is taken at
// an edge with i_valid high and o_stall low. output channel: o_valid / i_stall
// carry one result item (o_res) per request, held steady while i_stall is high.
// each item passes capture, check, walk and commit; the walk goes over the element
// memory (separate write and read ports), one entry per cycle:
//   insert shifts the entries from idx to n-1 up, erase shifts the entries behind
//   the erased range down, find reads up to all n entries (ends early on a hit),
//   read reads one entry, resize fills the new entries when it grows, all other
//   requests have no walk (n is the fill count).
// the longest walks are a find or an erase over a full array. items are
// handled one at a time; a new item is taken as soon as the previous one has
// committed, even while its result still waits in the output register. if that
// register is still held by i_stall when the next item is ready to commit, the
// engine waits in commit.
// reset (synchronous, active low) empties the array and drops any pending result;
// element contents stay undefined until written, which is never observable.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_engine_core
    import oae_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_res      o_res
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;
    logic     w_busy;

    oae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    oae_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .i_out_stall (i_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_valid),
        .o_res       (o_res)
    );

    assign o_stall = w_busy;

endmodule

`default_nettype wire
